// File: rtl/pfc_pkg.sv
package pfc_pkg;

	localparam int PIXEL_BITS         = 64;
	localparam int COMP_BITS          = 32;
	localparam int SLOTS              = 4;
	localparam int MAX_PIXEL_BITS     = 64;
	localparam int DEF_MAX_COMPONENTS = 4;
	localparam int LEN_STEPS          = 5;

	typedef enum logic [2:0] {
		CODE_R, CODE_G, CODE_B, CODE_A, CODE_L, CODE_D, CODE_S, CODE_X
	} code_e;

	typedef enum logic [2:0] {
		REG_IN_COUNT, REG_IN_CODES, REG_IN_SIZES, REG_OUT_COUNT,
		REG_OUT_CODES, REG_OUT_SIZES, REG_DEFAULT_PIXEL, REG_USE_DEFAULT
	} cfg_reg_e;

	typedef enum logic [1:0] {
		ST_OK, ST_BAD_LAYOUT, ST_BAD_FAMILY, ST_MISMATCH
	} status_e;

	localparam logic [7:0] FAM_RGBA = 8'h0F;
	localparam logic [7:0] FAM_LA   = 8'h18;
	localparam logic [7:0] FAM_DS   = 8'h60;
	localparam logic [7:0] BIT_X    = 8'h80;

	typedef struct packed {
		logic [2:0]  count;
		logic [11:0] codes;
		logic [23:0] sizes;
	} layout_cfg_t;

	typedef struct packed {
		layout_cfg_t in_lay;
		layout_cfg_t out_lay;
		logic [63:0] default_pixel;
		logic        use_default;
	} cfg_t;

	typedef struct packed {
		logic                   valid;
		logic                   uniq;
		logic [7:0]             present;
		logic [6:0]             rbits;
		logic [SLOTS-1:0]       used;
		logic [SLOTS-1:0][2:0]  code;
		logic [SLOTS-1:0][5:0]  size;
		logic [SLOTS-1:0][6:0]  off;
	} lay_info_t;

	typedef struct packed {
		status_e     status;
		logic [63:0] omask;
		logic [63:0] base;
	} dec_t;

	typedef struct packed {
		logic                      en;
		logic [5:0]                lsh;
		logic [COMP_BITS-1:0]      top_mask;
		logic [LEN_STEPS-1:0][5:0] len;
		logic [5:0]                psh;
		logic [PIXEL_BITS-1:0]     pm;
	} lane_t;

	function automatic logic in_family(input logic [7:0] present, input logic [7:0] fam);
		return ((present & fam) != 8'h00) && ((present & ~(fam | BIT_X)) == 8'h00);
	endfunction

	function automatic logic [63:0] low_mask64(input logic [6:0] n);
		return n[6] ? '1 : ((64'd1 << n[5:0]) - 64'd1);
	endfunction

endpackage

// File: rtl/pixel_format_converter_top.sv
// throughput: one pixel per cycle while the output is not stalled and no config write
// or hold is pending; five register stages with per-stage valid
// config writes are taken only while the pipeline is empty; input is held off
// while a write is offered and while hold_q, set by an accepted write, is high, so the derived layout settles
// reset clears valid bits, counts to 4 and all other config registers to 0;
// hold_q comes out of reset set, so input is held off until it clears
module pixel_format_converter_top #(
	parameter int MAX_COMPONENTS = pfc_pkg::DEF_MAX_COMPONENTS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // in_pixel
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // out_pixel
	output logic [1:0]  m_axis_tuser,   // status
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	import pfc_pkg::*;

	cfg_t                          cfg_q;
	logic                          hold_q;
	dec_t                          dec;
	lane_t [MAX_COMPONENTS-1:0]    lanes;

	logic                          vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic                          adv1, adv2, adv3, adv4, adv5;
	logic                          in_acc, cfg_acc;

	logic [63:0]                                pix_s1;
	logic [MAX_COMPONENTS-1:0][COMP_BITS-1:0]   comp_s2, comp_s3, comp_s4;
	logic [MAX_COMPONENTS-1:0][COMP_BITS-1:0]   ext, rep3, rep4;
	logic [63:0]                                pix_s5, pix_d;
	logic                                       last_s1, last_s2, last_s3, last_s4, last_s5;
	status_e                                    status_s5;

	function automatic logic [COMP_BITS-1:0] spread(input logic [COMP_BITS-1:0] t,
			input logic [5:0] n);
		return t | (t >> n);
	endfunction

	pfc_decode #(
		.MAX_COMPONENTS(MAX_COMPONENTS)
	) u_decode (
		.clk   (clk),
		.cfg   (cfg_q),
		.dec   (dec),
		.lanes (lanes)
	);

	// handshake
	assign adv5          = !vld_s5 || m_axis_tready;
	assign adv4          = !vld_s4 || adv5;
	assign adv3          = !vld_s3 || adv4;
	assign adv2          = !vld_s2 || adv3;
	assign adv1          = !vld_s1 || adv2;
	assign cfg_ready     = !(vld_s1 || vld_s2 || vld_s3 || vld_s4 || vld_s5);
	assign cfg_acc       = cfg_valid && cfg_ready;
	assign s_axis_tready = adv1 && !cfg_valid && !hold_q;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.in_lay.count  <= 3'd4;
			cfg_q.in_lay.codes  <= '0;
			cfg_q.in_lay.sizes  <= '0;
			cfg_q.out_lay.count <= 3'd4;
			cfg_q.out_lay.codes <= '0;
			cfg_q.out_lay.sizes <= '0;
			cfg_q.default_pixel <= '0;
			cfg_q.use_default   <= 1'b0;
			hold_q              <= 1'b1;
		end else begin
			hold_q <= cfg_acc;
			if (cfg_acc) begin
				case (cfg_reg_e'(cfg_index))
					REG_IN_COUNT:      cfg_q.in_lay.count  <= cfg_data[2:0];
					REG_IN_CODES:      cfg_q.in_lay.codes  <= cfg_data[11:0];
					REG_IN_SIZES:      cfg_q.in_lay.sizes  <= cfg_data[23:0];
					REG_OUT_COUNT:     cfg_q.out_lay.count <= cfg_data[2:0];
					REG_OUT_CODES:     cfg_q.out_lay.codes <= cfg_data[11:0];
					REG_OUT_SIZES:     cfg_q.out_lay.sizes <= cfg_data[23:0];
					REG_DEFAULT_PIXEL: cfg_q.default_pixel <= cfg_data;
					REG_USE_DEFAULT:   cfg_q.use_default   <= cfg_data[0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (adv1) vld_s1 <= in_acc;
			if (adv2) vld_s2 <= vld_s1;
			if (adv3) vld_s3 <= vld_s2;
			if (adv4) vld_s4 <= vld_s3;
			if (adv5) vld_s5 <= vld_s4;
		end
	end

	// extract each source component, top aligned in a 32-bit field
	always_comb begin
		logic [63:0] w;
		for (int o = 0; o < MAX_COMPONENTS; o++) begin
			w      = pix_s1 << lanes[o].lsh;
			ext[o] = w[63:32] & lanes[o].top_mask;
		end
	end

	// repeat the bit pattern by doubling its length
	always_comb begin
		for (int o = 0; o < MAX_COMPONENTS; o++) begin
			rep3[o] = spread(spread(comp_s2[o], lanes[o].len[0]), lanes[o].len[1]);
			rep4[o] = spread(spread(spread(comp_s3[o], lanes[o].len[2]),
				lanes[o].len[3]), lanes[o].len[4]);
		end
	end

	// place the top bits of each result into its output slot
	always_comb begin
		logic [63:0] w;
		pix_d = dec.base;
		for (int o = 0; o < MAX_COMPONENTS; o++) begin
			w = {comp_s4[o], 32'h0} >> lanes[o].psh;
			if (lanes[o].en)
				pix_d = pix_d | (w & lanes[o].pm);
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && in_acc) begin
			pix_s1  <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
		if (adv2) begin
			comp_s2 <= ext;
			last_s2 <= last_s1;
		end
		if (adv3) begin
			comp_s3 <= rep3;
			last_s3 <= last_s2;
		end
		if (adv4) begin
			comp_s4 <= rep4;
			last_s4 <= last_s3;
		end
		if (adv5) begin
			pix_s5    <= pix_d;
			status_s5 <= dec.status;
			last_s5   <= last_s4;
		end
	end

	assign m_axis_tvalid = vld_s5;
	assign m_axis_tdata  = pix_s5;
	assign m_axis_tuser  = status_s5;
	assign m_axis_tlast  = last_s5;

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser != 2'(ST_OK)) |-> m_axis_tdata == '0)
		else $error("error word carries nonzero pixel");

	a_cfg_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_acc |-> !in_acc ##1 !in_acc)
		else $error("pixel taken while layout settles");

	a_out_mask: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata & ~dec.omask) == '0)
		else $error("bits above output byte size");

endmodule

// File: rtl/pfc_decode.sv
module pfc_decode #(
	parameter int MAX_COMPONENTS = pfc_pkg::DEF_MAX_COMPONENTS
) (
	input  logic                                   clk,
	input  pfc_pkg::cfg_t                          cfg,
	output pfc_pkg::dec_t                          dec,
	output pfc_pkg::lane_t [MAX_COMPONENTS-1:0]    lanes
);
	import pfc_pkg::*;

	function automatic lay_info_t decode_lay(input layout_cfg_t c);
		lay_info_t  r;
		logic [8:0] tot;
		logic [9:0] rnd;
		logic [9:0] off;
		r        = '0;
		tot      = '0;
		r.valid  = (c.count != 3'd0) && (int'(c.count) <= MAX_COMPONENTS);
		r.uniq   = 1'b1;
		for (int i = 0; i < SLOTS; i++) begin
			r.code[i] = c.codes[3*i +: 3];
			r.size[i] = c.sizes[6*i +: 6];
			r.used[i] = int'(c.count) > i;
			if (r.used[i]) begin
				if (r.size[i] == 6'd0 || r.size[i] > 6'd32)
					r.valid = 1'b0;
				tot = tot + 9'(r.size[i]);
				r.present[r.code[i]] = 1'b1;
				for (int j = 0; j < i; j++) begin
					if (r.code[i] != CODE_X && r.code[j] == r.code[i])
						r.uniq = 1'b0;
				end
			end
		end
		if (tot > 9'(MAX_PIXEL_BITS))
			r.valid = 1'b0;
		rnd     = ((10'(tot) + 10'd7) >> 3) << 3;
		r.rbits = rnd[6:0];
		off     = rnd;
		for (int i = 0; i < SLOTS; i++) begin
			if (r.used[i])
				off = off - 10'(r.size[i]);
			r.off[i] = off[6:0];
		end
		return r;
	endfunction

	// first level: layout decode, status, slot matching
	lay_info_t                           li, lo;
	status_e                             status;
	logic [MAX_COMPONENTS-1:0]           men;
	logic [MAX_COMPONENTS-1:0][1:0]      midx;
	logic                                irgba, ila, ids, orgba, ola, ods, lum_map;

	lay_info_t                           li_q, lo_q;
	status_e                             st_q;
	logic [MAX_COMPONENTS-1:0]           men_q;
	logic [MAX_COMPONENTS-1:0][1:0]      midx_q;

	always_comb begin
		logic [2:0] want;
		logic       hit;
		li    = decode_lay(cfg.in_lay);
		lo    = decode_lay(cfg.out_lay);
		irgba = in_family(li.present, FAM_RGBA);
		ila   = in_family(li.present, FAM_LA);
		ids   = in_family(li.present, FAM_DS);
		orgba = in_family(lo.present, FAM_RGBA);
		ola   = in_family(lo.present, FAM_LA);
		ods   = in_family(lo.present, FAM_DS);
		if (!li.valid || !lo.valid)
			status = ST_BAD_LAYOUT;
		else if (!(irgba || ila || ids) || !(orgba || ola || ods))
			status = ST_BAD_FAMILY;
		else if ((irgba && !orgba) || (ila && !(ola || orgba)) || (ids && !ods))
			status = ST_MISMATCH;
		else if (!li.uniq || !lo.uniq)
			status = ST_BAD_LAYOUT;
		else
			status = ST_OK;
		lum_map = ila && orgba;
		for (int o = 0; o < MAX_COMPONENTS; o++) begin
			want = lo.code[o];
			if (lum_map && want <= 3'(CODE_B))
				want = CODE_L;
			hit     = 1'b0;
			midx[o] = 2'd0;
			// lowest matching input slot wins
			for (int i = SLOTS - 1; i >= 0; i--) begin
				if (li.used[i] && li.code[i] == want) begin
					hit     = 1'b1;
					midx[o] = 2'(i);
				end
			end
			men[o] = lo.used[o] && (lo.code[o] != CODE_X) && hit;
		end
	end

	always_ff @(posedge clk) begin
		li_q   <= li;
		lo_q   <= lo;
		st_q   <= status;
		men_q  <= men;
		midx_q <= midx;
	end

	// second level: shift amounts and masks per lane
	dec_t                               dec_d;
	lane_t [MAX_COMPONENTS-1:0]         lanes_d;

	always_comb begin
		logic [5:0]  isz, osz;
		logic [6:0]  ioff, ooff;
		logic [9:0]  sh;
		logic [63:0] pm_all;
		pm_all = '0;
		for (int o = 0; o < MAX_COMPONENTS; o++) begin
			isz  = li_q.size[midx_q[o]];
			ioff = li_q.off[midx_q[o]];
			osz  = lo_q.size[o];
			ooff = lo_q.off[o];
			lanes_d[o].en       = men_q[o] && (st_q == ST_OK);
			lanes_d[o].lsh      = 6'(8'd64 - 8'(ioff) - 8'(isz));
			lanes_d[o].top_mask = ~(32'hFFFF_FFFF >> isz);
			for (int k = 0; k < LEN_STEPS; k++) begin
				sh = 10'(isz) << k;
				lanes_d[o].len[k] = (sh > 10'd32) ? 6'd32 : sh[5:0];
			end
			lanes_d[o].psh = 6'(8'd64 - 8'(ooff) - 8'(osz));
			lanes_d[o].pm  = low_mask64(7'(osz)) << ooff[5:0];
			if (lanes_d[o].en)
				pm_all = pm_all | lanes_d[o].pm;
		end
		dec_d.status = st_q;
		dec_d.omask  = low_mask64(lo_q.rbits);
		dec_d.base   = (st_q == ST_OK && cfg.use_default) ?
			(cfg.default_pixel & dec_d.omask & ~pm_all) : '0;
	end

	always_ff @(posedge clk) begin
		dec   <= dec_d;
		lanes <= lanes_d;
	end

endmodule
